// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the converter checks (clk / arst_n in scope).
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// antecedent now implies consequent after the delay given by n
`define ASSERT_AFTER(lbl, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("assertion failed");

`endif

// ===== design/rgbhsv_pkg.sv =====
// ---------------------------------------------------------------------------
// rgbhsv_pkg
// Widths, hue offsets, pipeline stage type and divider step for the converter.
// ---------------------------------------------------------------------------
package rgbhsv_pkg;

	localparam int FRACTION_BITS = 16;
	localparam int CH_W          = 8;
	localparam int HUE_W         = 15;
	localparam int FRAC_W        = FRACTION_BITS + 1;
	localparam int HNUM_W        = 20;
	// numerator width shared by the two divider lanes
	localparam int NUM_W         = (FRACTION_BITS + CH_W + 1 > HNUM_W) ?
	                               FRACTION_BITS + CH_W + 1 : HNUM_W;
	localparam int QW            = NUM_W - CH_W;
	localparam int LATENCY       = QW + 2;

	localparam logic [HUE_W-1:0] HUE_RED   = 15'd0;
	localparam logic [HUE_W-1:0] HUE_GREEN = 15'd7680;
	localparam logic [HUE_W-1:0] HUE_BLUE  = 15'd15360;
	localparam logic [HUE_W-1:0] HUE_WRAP  = 15'd23040;
	localparam logic [CH_W-1:0]  FULL_SCALE = 8'd255;

	// 2^FRACTION_BITS = FULL_SCALE * VAL_Q + VAL_R
	localparam int VAL_Q = (1 << FRACTION_BITS) / int'(FULL_SCALE);
	localparam int VAL_R = (1 << FRACTION_BITS) % int'(FULL_SCALE);

	typedef struct packed {
		logic [CH_W-1:0]  hrem;
		logic [QW-1:0]    hq;
		logic [CH_W-1:0]  hd;
		logic [CH_W-1:0]  srem;
		logic [QW-1:0]    sq;
		logic [CH_W-1:0]  sd;
		logic [HUE_W-1:0] off;
		logic             neg;
		logic             gray;
		logic             black;
	} stage_t;

	// one restoring division step: shift in next numerator bit, subtract if it fits
	function automatic logic [CH_W+QW-1:0] div_step(input logic [CH_W-1:0] rem,
		input logic [QW-1:0] rq, input logic [CH_W-1:0] dv);
		logic [CH_W:0] t;
		logic [CH_W:0] diff;
		logic          ge;
		t    = {rem, rq[QW-1]};
		ge   = (t >= {1'b0, dv});
		diff = t - {1'b0, dv};
		return ge ? {diff[CH_W-1:0], rq[QW-2:0], 1'b1} : {t[CH_W-1:0], rq[QW-2:0], 1'b0};
	endfunction

endpackage

// ===== design/rgb_to_hsv_converter.sv =====
// ---------------------------------------------------------------------------
// rgb_to_hsv_converter
// Pipelined 8-bit RGB to HSV conversion, one pixel per clock.
// ---------------------------------------------------------------------------
// Usage:
//   An item (red, green, blue) is taken at each rising edge with start high
//   and busy low. busy is always low: the pipeline never stalls, so a pixel
//   may be offered in every cycle.
//   Each result (hue, saturation, brightness) is shown for exactly one cycle
//   with valid high, in the order the items came in. Throughput is one item
//   per clock. The pipeline is an input stage, the two restoring dividers
//   (hue, saturation) that resolve one quotient bit per stage over QW stages,
//   and an output stage; value is a constant multiply in the output stage.
//   The receiver cannot stall; results are not held.
//   Reset clears the valid bits of every stage, so items in flight are
//   dropped and no result appears until new items arrive.
// ---------------------------------------------------------------------------
module rgb_to_hsv_converter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [rgbhsv_pkg::CH_W-1:0]       red,
	input  logic [rgbhsv_pkg::CH_W-1:0]       green,
	input  logic [rgbhsv_pkg::CH_W-1:0]       blue,
	output logic                              valid,
	output logic [rgbhsv_pkg::HUE_W-1:0]      hue,
	output logic [rgbhsv_pkg::FRAC_W-1:0]     saturation,
	output logic [rgbhsv_pkg::FRAC_W-1:0]     brightness
);
	import rgbhsv_pkg::*;

	logic [CH_W-1:0]   mx, mn, dd, kk;
	logic              red_max, grn_max;
	logic [HUE_W-1:0]  off;
	logic              neg;
	logic [HNUM_W-1:0] hnum;
	logic [NUM_W-1:0]  hnum_x, snum_x;
	stage_t            st0;

	stage_t            stage_s [QW+1];
	logic [QW:0]       vld_s;

	logic [HUE_W-1:0]  hq_w;
	logic [HUE_W-1:0]  hue_n;
	logic [2*CH_W-1:0] vy, vt;
	logic [FRAC_W-1:0] val_n;
	logic              valid_q;
	logic [HUE_W-1:0]  hue_q;
	logic [FRAC_W-1:0] sat_q, val_q;

	assign busy = 1'b0;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		dd = mx - mn;
		red_max = (mx == red);
		grn_max = (mx == green);
		if (red_max) begin
			if (green >= blue) begin
				kk = green - blue; off = HUE_RED; neg = 1'b0;
			end else begin
				kk = blue - green; off = HUE_WRAP; neg = 1'b1;
			end
		end else if (grn_max) begin
			if (blue >= red) begin
				kk = blue - red; off = HUE_GREEN; neg = 1'b0;
			end else begin
				kk = red - blue; off = HUE_GREEN; neg = 1'b1;
			end
		end else begin
			if (red >= green) begin
				kk = red - green; off = HUE_BLUE; neg = 1'b0;
			end else begin
				kk = green - red; off = HUE_BLUE; neg = 1'b1;
			end
		end
		// 3840 * k = 4096 * k - 256 * k
		hnum   = (HNUM_W'(kk) << 12) - (HNUM_W'(kk) << 8);
		hnum_x = NUM_W'(hnum);
		snum_x = NUM_W'(dd) << FRACTION_BITS;

		st0.hrem  = hnum_x[NUM_W-1:QW];
		st0.hq    = hnum_x[QW-1:0];
		st0.hd    = dd;
		st0.srem  = snum_x[NUM_W-1:QW];
		st0.sq    = snum_x[QW-1:0];
		st0.sd    = mx;
		st0.off   = off;
		st0.neg   = neg;
		st0.gray  = (dd == '0);
		st0.black = (mx == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[QW-1:0], start & ~busy};
		end
	end

	always_ff @(posedge clk) begin
		stage_s[0] <= st0;
	end

	for (genvar i = 1; i <= QW; i++) begin : g_div
		stage_t nxt;

		always_comb begin
			nxt = stage_s[i-1];
			{nxt.hrem, nxt.hq} =
				div_step(stage_s[i-1].hrem, stage_s[i-1].hq, stage_s[i-1].hd);
			{nxt.srem, nxt.sq} =
				div_step(stage_s[i-1].srem, stage_s[i-1].sq, stage_s[i-1].sd);
		end

		always_ff @(posedge clk) begin
			stage_s[i] <= nxt;
		end
	end

	// negative term: subtract the ceiling of the quotient
	always_comb begin
		hq_w = HUE_W'(stage_s[QW].hq[11:0]);
		if (stage_s[QW].gray) begin
			hue_n = '0;
		end else if (stage_s[QW].neg) begin
			hue_n = stage_s[QW].off - hq_w - HUE_W'(stage_s[QW].hrem != '0);
		end else begin
			hue_n = stage_s[QW].off + hq_w;
		end
	end

	// value = mx * VAL_Q + floor(mx * VAL_R / 255), last term by the /255 identity
	always_comb begin
		vy    = (2*CH_W)'(stage_s[QW].sd) * (2*CH_W)'(VAL_R);
		vt    = vy + (vy >> CH_W) + (2*CH_W)'(1);
		val_n = FRAC_W'(stage_s[QW].sd) * FRAC_W'(VAL_Q) + FRAC_W'(vt[2*CH_W-1:CH_W]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		hue_q <= hue_n;
		sat_q <= stage_s[QW].black ? '0 : stage_s[QW].sq[FRAC_W-1:0];
		val_q <= val_n;
	end

	assign valid      = valid_q;
	assign hue        = hue_q;
	assign saturation = sat_q;
	assign brightness = val_q;

endmodule

// ===== design/rgbhsv_checker.sv =====
// ---------------------------------------------------------------------------
// rgbhsv_checker
// Port-level checks on the converter, bound into every rgb_to_hsv_converter instance.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rgbhsv_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [rgbhsv_pkg::CH_W-1:0]   red,
	input logic [rgbhsv_pkg::CH_W-1:0]   green,
	input logic [rgbhsv_pkg::CH_W-1:0]   blue,
	input logic                          valid,
	input logic [rgbhsv_pkg::HUE_W-1:0]  hue,
	input logic [rgbhsv_pkg::FRAC_W-1:0] saturation
);
	import rgbhsv_pkg::*;

	// every accepted item yields a result with valid high
	`ASSERT_AFTER(a_item_out, start && !busy, LATENCY, valid)
	// black pixel gives zero saturation
	`ASSERT_AFTER(a_black_sat, start && !busy && red == 0 && green == 0 && blue == 0, LATENCY, saturation == 0)
	// gray pixel gives zero hue
	`ASSERT_AFTER(a_gray_hue, start && !busy && red == green && green == blue, LATENCY, hue == 0)
	// hue stays below a full turn
	`ASSERT_ALWAYS(a_hue_range, !valid || hue < HUE_WRAP)

endmodule

bind rgb_to_hsv_converter rgbhsv_checker u_rgbhsv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.red        (red),
	.green      (green),
	.blue       (blue),
	.valid      (valid),
	.hue        (hue),
	.saturation (saturation)
);

// ===== verif/rgb_to_hsv_converter_tb.sv =====
// ---------------------------------------------------------------------------
// rgb_to_hsv_converter_tb
// Self-checking bench for the RGB to HSV converter. Pixels are offered with
// random gaps. Every accepted item is converted by an integer model held in
// the bench, and the resulting triple is queued. Each result strobe is then
// compared field by field against the oldest queued triple. The directed
// pixels cover black, gray, the primaries, ties for largest and the hue wrap
// near red. These are followed by uniform random pixels, near-gray and tied
// pixels, and a back-to-back stream.
// ---------------------------------------------------------------------------
module rgb_to_hsv_converter_tb;

	import rgbhsv_pkg::*;

	localparam int unsigned DEG_STEPS   = 64;
	localparam int unsigned SIXTH_TURN  = 60 * DEG_STEPS;
	localparam int unsigned FULL_TURN   = 360 * DEG_STEPS;
	localparam int          CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [FRAC_W-1:0] saturation;
		logic [FRAC_W-1:0] brightness;
	} hsv_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [CH_W-1:0]   red = '0;
	logic [CH_W-1:0]   green = '0;
	logic [CH_W-1:0]   blue = '0;
	logic              valid;
	logic [HUE_W-1:0]  hue;
	logic [FRAC_W-1:0] saturation;
	logic [FRAC_W-1:0] brightness;

	hsv_t pending_hsv[$];
	int   errors = 0;
	int   cycles = 0;

	rgb_to_hsv_converter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.valid      (valid),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic hsv_t convert_pixel(input logic [CH_W-1:0] r,
		input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
		longint unsigned mx;
		longint unsigned mn;
		longint unsigned d;
		longint unsigned num;
		longint unsigned h;
		longint unsigned s;
		longint unsigned v;
		hsv_t            res;
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		v = (mx << FRACTION_BITS) / 255;
		s = (mx != 0) ? (d << FRACTION_BITS) / mx : 0;
		h = 0;
		if (d != 0) begin
			// offset times d plus the signed term keeps the numerator positive
			if (mx == r) begin
				if (g >= b)
					num = SIXTH_TURN * (g - b);
				else
					num = FULL_TURN * d - SIXTH_TURN * (b - g);
			end else if (mx == g) begin
				num = 2 * SIXTH_TURN * d;
				if (b >= r)
					num += SIXTH_TURN * (b - r);
				else
					num -= SIXTH_TURN * (r - b);
			end else begin
				num = 4 * SIXTH_TURN * d;
				if (r >= g)
					num += SIXTH_TURN * (r - g);
				else
					num -= SIXTH_TURN * (g - r);
			end
			h = num / d;
		end
		res.hue        = h[HUE_W-1:0];
		res.saturation = s[FRAC_W-1:0];
		res.brightness = v[FRAC_W-1:0];
		return res;
	endfunction

	// results are checked before the item taken at the same edge is queued
	always @(posedge clk) begin : score
		hsv_t want;
		cycles <= cycles + 1;
		if (arst_n) begin
			if (valid) begin
				if (pending_hsv.size() == 0) begin
					$error("result with no item outstanding: hue %0d sat %0d val %0d",
						hue, saturation, brightness);
					errors++;
				end else begin
					want = pending_hsv.pop_front();
					if (hue !== want.hue) begin
						$error("hue: expected %0d, got %0d", want.hue, hue);
						errors++;
					end
					if (saturation !== want.saturation) begin
						$error("saturation: expected %0d, got %0d", want.saturation, saturation);
						errors++;
					end
					if (brightness !== want.brightness) begin
						$error("brightness: expected %0d, got %0d", want.brightness, brightness);
						errors++;
					end
				end
			end
			if (start && !busy)
				pending_hsv.push_back(convert_pixel(red, green, blue));
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
		input logic [CH_W-1:0] b);
		@(negedge clk);
		start <= 1'b1;
		red   <= r;
		green <= g;
		blue  <= b;
		do @(posedge clk); while (busy);
	endtask

	// drive start low, with junk on the channels
	task automatic idle(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
			red   <= CH_W'($urandom());
			green <= CH_W'($urandom());
			blue  <= CH_W'($urandom());
		end
	endtask

	function automatic int gap_len();
		int sel;
		sel = int'($urandom_range(0, 99));
		if (sel < 60)
			return 0;
		else if (sel < 92)
			return int'($urandom_range(1, 3));
		else
			return int'($urandom_range(10, 40));
	endfunction

	task automatic drain();
		idle(1);
		while (pending_hsv.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		logic [3*CH_W-1:0] pix[$];
		pix = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101,
			24'hFF0000, 24'h00FF00, 24'h0000FF,
			24'hFF0001, 24'hFF00FE, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
			24'h010000, 24'h000100, 24'h000001,
			24'hFFFE00, 24'hFEFF00, 24'h00FEFF, 24'h00FFFE,
			24'h010100, 24'hAA5500, 24'h55AAFF, 24'hFEFFFF, 24'hFFFEFE};
		foreach (pix[i]) begin
			send_pixel(pix[i][23:16], pix[i][15:8], pix[i][7:0]);
			idle(gap_len());
		end
	endtask

	task automatic test_random_pixels(input int n);
		repeat (n) begin
			send_pixel(CH_W'($urandom()), CH_W'($urandom()), CH_W'($urandom()));
			idle(gap_len());
		end
	endtask

	// gray, tied largest, tied smallest and narrow spreads
	task automatic test_ties_and_grays(input int n);
		logic [CH_W-1:0] a;
		logic [CH_W-1:0] c;
		logic [CH_W-1:0] ch[3];
		int              mode;
		repeat (n) begin
			a    = CH_W'($urandom());
			c    = CH_W'($urandom());
			mode = int'($urandom_range(0, 3));
			case (mode)
				0: begin
					ch = '{a, a, a};
				end
				1: begin
					ch = '{a, a, c};
				end
				2: begin
					ch = '{c, a, a};
				end
				default: begin
					ch[0] = a;
					ch[1] = (a > 252) ? a - CH_W'($urandom_range(0, 3)) :
						a + CH_W'($urandom_range(0, 3));
					ch[2] = (a < 3) ? a + CH_W'($urandom_range(0, 3)) :
						a - CH_W'($urandom_range(0, 3));
				end
			endcase
			case ($urandom_range(0, 2))
				0: send_pixel(ch[0], ch[1], ch[2]);
				1: send_pixel(ch[2], ch[0], ch[1]);
				default: send_pixel(ch[1], ch[2], ch[0]);
			endcase
			idle(gap_len());
		end
	endtask

	task automatic test_stream(input int n);
		for (int i = 0; i < n; i++) begin
			send_pixel(CH_W'($urandom()), CH_W'($urandom()), CH_W'($urandom()));
			if (i == n / 2)
				drain();
		end
		idle(1);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_pixels(800);
		test_ties_and_grays(400);
		test_stream(330);
		while (pending_hsv.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
